// ===== hdl/infix_to_postfix_converter_assert.svh =====
// Assertion macros shared by the converter modules
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define ITP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define ITP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/itp_pkg.sv =====
// Shared types, constants and functions for the infix to postfix converter
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  typedef logic [2:0] code_t;

  localparam code_t CODE_OPEN = 3'd0;
  localparam code_t CODE_ADD  = 3'd1;
  localparam code_t CODE_SUB  = 3'd2;
  localparam code_t CODE_MUL  = 3'd3;
  localparam code_t CODE_DIV  = 3'd4;
  localparam code_t CODE_POW  = 3'd5;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_LETTER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER
  } cls_t;

  typedef enum logic [1:0] {
    RES_LETTER,
    RES_TOP,
    RES_OVERFLOW,
    RES_UNMATCHED
  } res_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_FLUSH,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic     load;
    logic     push;
    logic     pop;
    logic     gen;
    res_sel_t sel;
    logic     done;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic end_item;
    logic sp_zero;
    logic sp_full;
    logic top_open;
    logic top_higher;
    logic hold_vld;
    logic out_free;
  } sts_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic code_t sym_code(input logic [7:0] c);
    code_t r;
    unique case (c)
      CH_ADD:  r = CODE_ADD;
      CH_SUB:  r = CODE_SUB;
      CH_MUL:  r = CODE_MUL;
      CH_DIV:  r = CODE_DIV;
      CH_POW:  r = CODE_POW;
      default: r = CODE_OPEN;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input code_t c);
    logic [7:0] r;
    unique case (c)
      CODE_OPEN: r = CH_OPEN;
      CODE_ADD:  r = CH_ADD;
      CODE_SUB:  r = CH_SUB;
      CODE_MUL:  r = CH_MUL;
      CODE_DIV:  r = CH_DIV;
      CODE_POW:  r = CH_POW;
      default:   r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] code_prec(input code_t c);
    logic [1:0] r;
    unique case (c)
      CODE_ADD, CODE_SUB: r = 2'd1;
      CODE_MUL, CODE_DIV: r = 2'd2;
      CODE_POW:           r = 2'd3;
      default:            r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/itp_if.sv =====
// Channel interfaces for the converter input and result transactions
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output out_symbol, output last, output status, input ready);
  modport sink   (input valid, input out_symbol, input last, input status, output ready);
endinterface

// ===== hdl/itp_datapath.sv =====
// Datapath: item register, operator stack, result hold and output registers
`include "infix_to_postfix_converter_assert.svh"

module itp_datapath
  import itp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_symbol,
  input  logic       in_end,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_symbol,
  output logic       out_last,
  output status_t    out_status
);

  logic [7:0] sym_r;
  logic       end_r;
  code_t      stack_r [STACK_DEPTH];
  logic [SP_W-1:0] sp_r, sp_nxt, sp_m1;
  code_t      top_code;

  logic       hold_vld_r, hold_vld_nxt;
  logic [7:0] hold_sym_r;
  status_t    hold_st_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_sym_r;
  logic       out_last_r;
  status_t    out_st_r;

  logic [7:0] gen_sym;
  status_t    gen_st;
  logic       load_out, load_hold, out_from_hold;
  cls_t       cls;

  assign sp_m1    = sp_r - SP_W'(1);
  assign top_code = stack_r[sp_m1[IDX_W-1:0]];

  always_comb begin
    if (is_letter(sym_r))            cls = CLS_LETTER;
    else if (sym_r == CH_OPEN)       cls = CLS_OPEN;
    else if (sym_r == CH_CLOSE)      cls = CLS_CLOSE;
    else if (sym_code(sym_r) != CODE_OPEN) cls = CLS_OPER;
    else                             cls = CLS_OTHER;
  end

  always_comb begin
    sts.cls        = cls;
    sts.end_item   = end_r;
    sts.sp_zero    = (sp_r == '0);
    sts.sp_full    = (sp_r >= SP_W'(STACK_DEPTH));
    sts.top_open   = (top_code == CODE_OPEN);
    sts.top_higher = (code_prec(top_code) > code_prec(sym_code(sym_r)));
    sts.hold_vld   = hold_vld_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    unique case (cmd.sel)
      RES_LETTER:    begin gen_sym = sym_r;               gen_st = ST_OK;        end
      RES_TOP:       begin gen_sym = code_char(top_code); gen_st = ST_OK;        end
      RES_OVERFLOW:  begin gen_sym = CH_NUL;              gen_st = ST_OVERFLOW;  end
      RES_UNMATCHED: begin gen_sym = CH_NUL;              gen_st = ST_UNMATCHED; end
      default:       begin gen_sym = CH_NUL;              gen_st = ST_OK;        end
    endcase
  end

  // A result is held back one step until it is known whether another follows
  always_comb begin
    out_from_hold = hold_vld_r && (cmd.gen || cmd.done);
    load_out      = out_from_hold || (cmd.gen && cmd.done);
    load_hold     = cmd.gen && (hold_vld_r || !cmd.done);
    if (load_hold)     hold_vld_nxt = 1'b1;
    else if (cmd.done) hold_vld_nxt = 1'b0;
    else               hold_vld_nxt = hold_vld_r;
    if (load_out)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
    if (cmd.push)      sp_nxt = sp_r + SP_W'(1);
    else if (cmd.pop)  sp_nxt = sp_m1;
    else               sp_nxt = sp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r        <= sp_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_r <= in_symbol;
      end_r <= in_end;
    end
    if (cmd.push) begin
      stack_r[sp_r[IDX_W-1:0]] <= sym_code(sym_r);
    end
    if (load_hold) begin
      hold_sym_r <= gen_sym;
      hold_st_r  <= gen_st;
    end
    if (load_out) begin
      if (out_from_hold) begin
        out_sym_r  <= hold_sym_r;
        out_st_r   <= hold_st_r;
        out_last_r <= !cmd.gen;
      end else begin
        out_sym_r  <= gen_sym;
        out_st_r   <= gen_st;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_sym_r;
  assign out_last   = out_last_r;
  assign out_status = out_st_r;

  `ITP_ASSERT_NOW(a_sp_in_range, 1'b1, sp_r <= SP_W'(STACK_DEPTH), "stack pointer past depth")
  `ITP_ASSERT_NOW(a_no_push_full, cmd.push, sp_r < SP_W'(STACK_DEPTH), "push on full stack")
  `ITP_ASSERT_NOW(a_no_pop_empty, cmd.pop, sp_r != '0, "pop on empty stack")
  `ITP_ASSERT_NOW(a_load_out_free, load_out, !out_valid_r || out_ready, "output overwritten")

endmodule

// ===== hdl/itp_controller.sv =====
// Controller: sequences the stack and result steps for each input transaction
`include "infix_to_postfix_converter_assert.svh"

module itp_controller
  import itp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    fin       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (sts.out_free) begin
          unique case (sts.cls)
            CLS_LETTER: begin
              cmd.gen = 1'b1;
              cmd.sel = RES_LETTER;
              fin     = 1'b1;
            end
            CLS_OPEN: begin
              if (sts.sp_full) begin
                cmd.gen = 1'b1;
                cmd.sel = RES_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
              end
              fin = 1'b1;
            end
            CLS_CLOSE: begin
              if (sts.sp_zero) begin
                cmd.gen = 1'b1;
                cmd.sel = RES_UNMATCHED;
                fin     = 1'b1;
              end else begin
                cmd.pop = 1'b1;
                if (sts.top_open) begin
                  fin = 1'b1;
                end else begin
                  cmd.gen = 1'b1;
                  cmd.sel = RES_TOP;
                end
              end
            end
            CLS_OPER: begin
              if (!sts.sp_zero && sts.top_higher) begin
                cmd.pop = 1'b1;
                cmd.gen = 1'b1;
                cmd.sel = RES_TOP;
              end else begin
                if (sts.sp_full) begin
                  cmd.gen = 1'b1;
                  cmd.sel = RES_OVERFLOW;
                end else begin
                  cmd.push = 1'b1;
                end
                fin = 1'b1;
              end
            end
            CLS_OTHER: fin = 1'b1;
            default:   fin = 1'b1;
          endcase
          if (fin) begin
            if (sts.end_item) state_nxt = S_FLUSH;
            else              cmd.done  = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          if (sts.sp_zero) begin
            cmd.done = 1'b1;
          end else begin
            cmd.pop = 1'b1;
            if (!sts.top_open) begin
              cmd.gen = 1'b1;
              cmd.sel = RES_TOP;
            end
          end
        end
      end
      S_DRAIN: begin
        if (sts.out_free) cmd.done = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.done) begin
      state_nxt = (sts.hold_vld && cmd.gen) ? S_DRAIN : S_IDLE;
    end
  end

  `ITP_ASSERT_NOW(a_idle_hold_empty, state_r == S_IDLE, !sts.hold_vld, "held result at idle")
  `ITP_ASSERT_NOW(a_push_pop_excl, cmd.push || cmd.pop, !(cmd.push && cmd.pop), "push with pop")
  `ITP_ASSERT_NEXT(a_drain_ends, state_r == S_DRAIN && sts.out_free, state_r == S_IDLE,
                   "drain did not finish")

endmodule

// ===== hdl/infix_to_postfix_converter.sv =====
// Top level: infix to postfix converter with an operator stack.
// out_valid comes from the output register: a result goes straight there only when it is the only one
// and no flush follows, else it passes through the hold register first, as it is held there to set last.
// Input: one character at a time, as in_ready is high only in idle; each operator popped, the end flush
// with each '(' it drops, a held result that must drain and each output stall delay the next character.
// Reset (rst_n, synchronous, active low) empties the stack and clears all control state.
module infix_to_postfix_converter
  import itp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  itp_in_if.sink   in_chan,
  itp_out_if.source out_chan
);

  cmd_t    cmd;
  sts_t    sts;
  status_t out_st;

  itp_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_symbol  (in_chan.symbol),
    .in_end     (in_chan.end_of_expr),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_symbol (out_chan.out_symbol),
    .out_last   (out_chan.last),
    .out_status (out_st)
  );

  assign out_chan.status = out_st;

endmodule

// ===== tb/sv/tb_infix_to_postfix_converter.sv =====
// Self-checking testbench for the infix to postfix converter: directed table, full-stack cases, random expressions
module tb_infix_to_postfix_converter;
  import itp_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int RANDOM_ITEMS   = 180;
  localparam int PAUSE_AT       = 80;
  localparam int QUIET_AT       = 150;
  localparam int N_DIRECTED     = 26;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    status_t    status;
  } postfix_res_t;

  typedef struct packed {
    logic         given;
    postfix_res_t res;
  } given_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       eoe;
    logic       given;
    logic [7:0] ref_sym;
    logic       ref_last;
    status_t    ref_st;
  } stim_row_t;

  localparam logic [7:0] OP_CHARS [5] = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW};

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{CH_UPPER_A, 1'b0, 1'b1, CH_UPPER_A, 1'b1, ST_OK},
    '{CH_CLOSE,   1'b0, 1'b1, CH_NUL,     1'b1, ST_UNMATCHED},
    '{CH_LOWER_Z, 1'b1, 1'b1, CH_LOWER_Z, 1'b1, ST_OK},
    '{CH_UPPER_Z, 1'b0, 1'b1, CH_UPPER_Z, 1'b1, ST_OK},
    '{CH_LOWER_A, 1'b0, 1'b1, CH_LOWER_A, 1'b1, ST_OK},
    '{8'h00,      1'b1, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{8'hFF,      1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{8'h40,      1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{8'h5B,      1'b1, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{8'h60,      1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{8'h7B,      1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    // p+q*r^s-t : '-' pops the higher operators, stops at '+'
    '{"p",        1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{CH_ADD,     1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{"q",        1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{CH_MUL,     1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{"r",        1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{CH_POW,     1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{"s",        1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{CH_SUB,     1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{"t",        1'b1, 1'b0, CH_NUL,     1'b0, ST_OK},
    // ((u/v) : unmatched open dropped silently in the flush
    '{CH_OPEN,    1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{CH_OPEN,    1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{"u",        1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{CH_DIV,     1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{"v",        1'b0, 1'b0, CH_NUL,     1'b0, ST_OK},
    '{CH_CLOSE,   1'b1, 1'b0, CH_NUL,     1'b0, ST_OK}
  };

  localparam given_t NO_REF = '0;

  logic clk = 1'b0;
  logic rst_n;

  itp_in_if  in_if ();
  itp_out_if out_if ();

  infix_to_postfix_converter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #6 clk = ~clk;

  code_t        op_stack [STACK_DEPTH];
  int unsigned  stack_fill = 0;
  postfix_res_t fresh_res [$];
  postfix_res_t postfix_q [$];
  given_t       given_q [$];
  logic [7:0]   expr_q [$];
  int unsigned  errors = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  stall_left = 0;
  logic         idle_on = 1'b1;
  postfix_res_t want;
  given_t       given_now;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic decode_op(input logic [7:0] c, output code_t k);
    k = CODE_OPEN;
    case (c)
      CH_ADD:  k = CODE_ADD;
      CH_SUB:  k = CODE_SUB;
      CH_MUL:  k = CODE_MUL;
      CH_DIV:  k = CODE_DIV;
      CH_POW:  k = CODE_POW;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic int op_rank(input code_t k);
    case (k)
      CODE_ADD, CODE_SUB: return 1;
      CODE_MUL, CODE_DIV: return 2;
      CODE_POW:           return 3;
      default:            return 0;
    endcase
  endfunction

  function automatic logic [7:0] op_symbol(input code_t k);
    case (k)
      CODE_ADD: return CH_ADD;
      CODE_SUB: return CH_SUB;
      CODE_MUL: return CH_MUL;
      CODE_DIV: return CH_DIV;
      CODE_POW: return CH_POW;
      default:  return CH_OPEN;
    endcase
  endfunction

  function automatic void emit_res(input logic [7:0] c, input status_t st);
    fresh_res.push_back('{c, 1'b0, st});
  endfunction

  function automatic void push_code(input code_t k);
    if (stack_fill >= STACK_DEPTH) emit_res(CH_NUL, ST_OVERFLOW);
    else begin
      op_stack[stack_fill] = k;
      stack_fill++;
    end
  endfunction

  // Postfix results caused by one input character, into fresh_res
  function automatic void convert_symbol(input logic [7:0] c, input logic eoe);
    code_t k;
    logic  is_op;
    logic  matched;
    fresh_res.delete();
    is_op = decode_op(c, k);
    if (is_alpha(c)) emit_res(c, ST_OK);
    else if (c == CH_OPEN) push_code(CODE_OPEN);
    else if (c == CH_CLOSE) begin
      matched = 1'b0;
      while (stack_fill > 0 && !matched) begin
        stack_fill--;
        if (op_stack[stack_fill] == CODE_OPEN) matched = 1'b1;
        else emit_res(op_symbol(op_stack[stack_fill]), ST_OK);
      end
      if (!matched) emit_res(CH_NUL, ST_UNMATCHED);
    end else if (is_op) begin
      while (stack_fill > 0 && op_rank(op_stack[stack_fill - 1]) > op_rank(k)) begin
        stack_fill--;
        emit_res(op_symbol(op_stack[stack_fill]), ST_OK);
      end
      push_code(k);
    end
    if (eoe) begin
      while (stack_fill > 0) begin
        stack_fill--;
        if (op_stack[stack_fill] != CODE_OPEN) emit_res(op_symbol(op_stack[stack_fill]), ST_OK);
      end
    end
    if (fresh_res.size() > 0) fresh_res[fresh_res.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_operand(input int unsigned lvl);
    if (lvl < 4 && $urandom_range(0, 3) == 0) begin
      expr_q.push_back(CH_OPEN);
      add_infix(lvl + 1);
      expr_q.push_back(CH_CLOSE);
    end else if ($urandom_range(0, 1) == 0) begin
      expr_q.push_back(8'(CH_UPPER_A + $urandom_range(0, 25)));
    end else begin
      expr_q.push_back(8'(CH_LOWER_A + $urandom_range(0, 25)));
    end
  endfunction

  function automatic void add_infix(input int unsigned lvl);
    int unsigned n_ops;
    n_ops = $urandom_range(0, 3);
    add_operand(lvl);
    repeat (n_ops) begin
      expr_q.push_back(OP_CHARS[$urandom_range(0, 4)]);
      add_operand(lvl);
    end
  endfunction

  task automatic send_symbol(input logic [7:0] c, input logic eoe, input given_t g);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    given_q.push_back(g);
    in_if.valid       <= 1'b1;
    in_if.symbol      <= c;
    in_if.end_of_expr <= eoe;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
  endtask

  // Result sink with random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_if.ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 5);
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready  <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (postfix_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got sym %h last %b status %0d",
                   $time, out_if.out_symbol, out_if.last, out_if.status);
        end else begin
          want = postfix_q.pop_front();
          if (out_if.out_symbol !== want.sym || out_if.last !== want.last ||
              out_if.status !== want.status) begin
            errors++;
            $display("%0t: mismatch, expected sym %h last %b status %0d, got sym %h last %b status %0d",
                     $time, want.sym, want.last, want.status,
                     out_if.out_symbol, out_if.last, out_if.status);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        given_now = given_q.pop_front();
        convert_symbol(in_if.symbol, in_if.end_of_expr);
        if (given_now.given) postfix_q.push_back(given_now.res);
        else foreach (fresh_res[i]) postfix_q.push_back(fresh_res[i]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_infix_to_postfix_converter NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned counted;
    int unsigned nest;
    logic        broken;
    logic        eoe;
    logic        paused;
    code_t       k;
    stim_row_t   row;
    counted = 0;
    paused  = 1'b0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.symbol      <= 8'h00;
    in_if.end_of_expr <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      send_symbol(row.sym, row.eoe,
                  '{row.given, '{row.ref_sym, row.ref_last, row.ref_st}});
    end

    // full stack: '(' overflows, then ')' pops all and finds no open
    repeat (STACK_DEPTH) send_symbol(CH_POW, 1'b0, NO_REF);
    send_symbol(CH_OPEN, 1'b0, '{1'b1, '{CH_NUL, 1'b1, ST_OVERFLOW}});
    send_symbol(CH_CLOSE, 1'b0, NO_REF);
    // full stack: equal precedence overflows, then the end flush
    repeat (STACK_DEPTH) send_symbol(CH_ADD, 1'b0, NO_REF);
    send_symbol(CH_SUB, 1'b1, NO_REF);
    wait_all_results();

    while (counted < RANDOM_ITEMS) begin
      expr_q.delete();
      if ($urandom_range(0, 11) == 0) begin
        nest = $urandom_range(28, 36);
        repeat (nest) expr_q.push_back(CH_OPEN);
        add_infix(4);
        repeat (nest - $urandom_range(0, 2)) expr_q.push_back(CH_CLOSE);
      end else begin
        add_infix(0);
      end
      broken = ($urandom_range(0, 6) == 0);
      if (broken) begin
        case ($urandom_range(0, 3))
          0: expr_q.insert($urandom_range(0, expr_q.size()), 8'($urandom_range(0, 255)));
          1: expr_q.delete($urandom_range(0, expr_q.size() - 1));
          2: expr_q.insert($urandom_range(0, expr_q.size()), CH_CLOSE);
          default: expr_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      idle_on = (counted < QUIET_AT) && ($urandom_range(0, 3) != 0);
      if (counted >= PAUSE_AT && !paused) begin
        paused = 1'b1;
        wait_all_results();
      end
      for (int n = 0; n < expr_q.size(); n++) begin
        eoe = (n == expr_q.size() - 1);
        send_symbol(expr_q[n], eoe, NO_REF);
        if (is_alpha(expr_q[n]) || expr_q[n] == CH_OPEN || expr_q[n] == CH_CLOSE ||
            decode_op(expr_q[n], k) || eoe)
          counted++;
      end
    end

    idle_on = 1'b0;
    wait_all_results();
    repeat (40) @(posedge clk);
    if (errors == 0 && postfix_q.size() == 0) begin
      $display("tb_infix_to_postfix_converter OK");
    end else begin
      $display("tb_infix_to_postfix_converter NOT OK");
    end
    $finish;
  end

endmodule
